>>> hdl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Types, constants and helpers shared by the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int CW = 32;
	localparam int FRAC_BITS_DEF = 16;
	// full-precision plane score: four products plus the offset term
	localparam int FW = 2 * CW + 3;
	// divider remainder, one spare bit over the denominator
	localparam int RW = FW + 2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW:0] mag_t;
	typedef logic signed [FW-1:0] score_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vtx_t;

	typedef struct packed {
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v0_w;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v1_w;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
		coord_t v2_w;
	} tri_in_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		coord_t out_w;
		logic [1:0] tri_status;
		logic end_of_triangle;
		logic last;
	} result_t;

	typedef struct packed {
		coord_t nx;
		coord_t ny;
		coord_t nz;
		coord_t nw;
		coord_t offset;
	} plane_t;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_NX = 3'd0;
	localparam reg_idx_t REG_NY = 3'd1;
	localparam reg_idx_t REG_NZ = 3'd2;
	localparam reg_idx_t REG_NW = 3'd3;
	localparam reg_idx_t REG_OFFSET = 3'd4;

	localparam logic [1:0] ST_KEPT = 2'd0;
	localparam logic [1:0] ST_CLIP = 2'd1;
	localparam logic [1:0] ST_CULL = 2'd2;

	typedef enum logic [1:0] {CROSS_NONE, CROSS_A_OUT, CROSS_B_OUT} cross_t;

	typedef struct packed {
		logic pos_a;
		logic pos_b;
		cross_t crossing;
	} edge_flags_t;

	// payload that travels with one edge through the divider stages
	typedef struct packed {
		vtx_t a;
		vtx_t b;
		mag_t [3:0] mag;
		logic [3:0] dneg;
		edge_flags_t flags;
	} edge_carry_t;

	typedef enum logic [2:0] {
		K_KEEP, K_CULL, K_V1_OUT, K_V2_OUT, K_V0_OUT, K_V1_IN, K_V2_IN, K_V0_IN
	} kind_t;

	typedef enum logic [2:0] {PT_V0, PT_V1, PT_V2, PT_I01, PT_I02, PT_I12} pt_t;

	typedef struct packed {
		kind_t kind;
		vtx_t [5:0] pts;
	} tri_rec_t;

	function automatic logic [2:0] kind_count(kind_t k);
		logic [2:0] n;
		case (k)
			K_CULL: n = 3'd1;
			K_V1_OUT, K_V2_OUT, K_V0_OUT: n = 3'd6;
			default: n = 3'd3;
		endcase
		return n;
	endfunction

	function automatic pt_t pick_point(kind_t k, logic [2:0] idx);
		pt_t seq [0:5];
		pt_t p;
		case (k)
			K_V1_OUT: seq = '{PT_V0, PT_I01, PT_V2, PT_I01, PT_I12, PT_V2};
			K_V2_OUT: seq = '{PT_V0, PT_V1, PT_I02, PT_V1, PT_I12, PT_I02};
			K_V0_OUT: seq = '{PT_I01, PT_V1, PT_V2, PT_I01, PT_V2, PT_I02};
			K_V1_IN: seq = '{PT_I01, PT_V1, PT_I12, PT_V0, PT_V0, PT_V0};
			K_V2_IN: seq = '{PT_I02, PT_I12, PT_V2, PT_V0, PT_V0, PT_V0};
			K_V0_IN: seq = '{PT_V0, PT_I01, PT_I02, PT_V0, PT_V0, PT_V0};
			default: seq = '{PT_V0, PT_V1, PT_V2, PT_V0, PT_V0, PT_V0};
		endcase
		p = (idx <= 3'd5) ? seq[idx] : PT_V0;
		return p;
	endfunction

endpackage

>>> hdl/tpc_score_lane.sv
// ----------------------------------------------------------------------------
// tpc_score_lane
// Scores one vertex against the plane: products, then the full-width sum.
// ----------------------------------------------------------------------------
module tpc_score_lane #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  tpc_pkg::plane_t plane,
	input  tpc_pkg::vtx_t v,
	output tpc_pkg::vtx_t v_s2,
	output tpc_pkg::score_t f_s2
);
	import tpc_pkg::*;

	logic signed [2*CW-1:0] prod_s1 [4];
	score_t off_s1;
	vtx_t v_s1;

	always_ff @(posedge clk) begin
		prod_s1[0] <= plane.nx * v.x;
		prod_s1[1] <= plane.ny * v.y;
		prod_s1[2] <= plane.nz * v.z;
		prod_s1[3] <= plane.nw * v.w;
		off_s1 <= FW'(plane.offset) <<< FRAC_BITS;
		v_s1 <= v;
	end

	always_ff @(posedge clk) begin
		f_s2 <= off_s1 + FW'(prod_s1[0]) + FW'(prod_s1[1]) + FW'(prod_s1[2])
			+ FW'(prod_s1[3]);
		v_s2 <= v_s1;
	end

endmodule

>>> hdl/tpc_edge_lane.sv
// ----------------------------------------------------------------------------
// tpc_edge_lane
// One edge: crossing test, bit-per-stage divide for t, then interpolation.
// ----------------------------------------------------------------------------
module tpc_edge_lane #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  tpc_pkg::vtx_t a,
	input  tpc_pkg::vtx_t b,
	input  tpc_pkg::score_t f_a,
	input  tpc_pkg::score_t f_b,
	output tpc_pkg::vtx_t a_o,
	output tpc_pkg::vtx_t b_o,
	output tpc_pkg::vtx_t p_o,
	output tpc_pkg::edge_flags_t flags_o
);
	import tpc_pkg::*;

	logic signed [FW:0] fa_e, fb_e, df;
	logic signed [CW:0] d [4];
	coord_t ca [4], cb [4];
	edge_carry_t carry_in;
	logic zero_a, zero_b;

	logic [RW-1:0] rem_s [FRAC_BITS+1];
	logic [RW-1:0] den_s [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] quo_s [FRAC_BITS+1];
	edge_carry_t carry_s [FRAC_BITS+1];

	logic [CW:0] sh_m [4];
	edge_carry_t carry_m;
	vtx_t p_next;

	assign ca = '{a.x, a.y, a.z, a.w};
	assign cb = '{b.x, b.y, b.z, b.w};

	always_comb begin
		fa_e = {f_a[FW-1], f_a};
		fb_e = {f_b[FW-1], f_b};
		df = fa_e - fb_e;
		zero_a = (f_a == '0);
		zero_b = (f_b == '0);
		carry_in.a = a;
		carry_in.b = b;
		for (int k = 0; k < 4; k++) begin
			d[k] = {cb[k][CW-1], cb[k]} - {ca[k][CW-1], ca[k]};
			carry_in.mag[3-k] = $unsigned(d[k] < 0 ? -d[k] : d[k]);
			carry_in.dneg[3-k] = d[k] < 0;
		end
		carry_in.flags.pos_a = !f_a[FW-1] && !zero_a;
		carry_in.flags.pos_b = !f_b[FW-1] && !zero_b;
		if (zero_a || zero_b || (f_a[FW-1] == f_b[FW-1]))
			carry_in.flags.crossing = CROSS_NONE;
		else if (f_a[FW-1])
			carry_in.flags.crossing = CROSS_B_OUT;
		else
			carry_in.flags.crossing = CROSS_A_OUT;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= RW'($unsigned(fa_e < 0 ? -fa_e : fa_e));
		den_s[0] <= RW'($unsigned(df < 0 ? -df : df));
		quo_s[0] <= '0;
		carry_s[0] <= carry_in;
	end

	// restoring divide, one quotient bit per stage
	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
		logic [RW-1:0] r2;
		logic ge;
		assign r2 = rem_s[j] << 1;
		assign ge = r2 >= den_s[j];
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? r2 - den_s[j] : r2;
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= {quo_s[j][FRAC_BITS-2:0], ge};
			carry_s[j+1] <= carry_s[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++)
			sh_m[k] <= (CW + 1)'((CW + FRAC_BITS + 1)'(carry_s[FRAC_BITS].mag[3-k]
				* quo_s[FRAC_BITS]) >> FRAC_BITS);
		carry_m <= carry_s[FRAC_BITS];
	end

	always_comb begin
		p_next.x = carry_m.dneg[3] ? carry_m.a.x - coord_t'(sh_m[0][CW-1:0])
			: carry_m.a.x + coord_t'(sh_m[0][CW-1:0]);
		p_next.y = carry_m.dneg[2] ? carry_m.a.y - coord_t'(sh_m[1][CW-1:0])
			: carry_m.a.y + coord_t'(sh_m[1][CW-1:0]);
		p_next.z = carry_m.dneg[1] ? carry_m.a.z - coord_t'(sh_m[2][CW-1:0])
			: carry_m.a.z + coord_t'(sh_m[2][CW-1:0]);
		p_next.w = carry_m.dneg[0] ? carry_m.a.w - coord_t'(sh_m[3][CW-1:0])
			: carry_m.a.w + coord_t'(sh_m[3][CW-1:0]);
	end

	always_ff @(posedge clk) begin
		p_o <= p_next;
		a_o <= carry_m.a;
		b_o <= carry_m.b;
		flags_o <= carry_m.flags;
	end

endmodule

>>> hdl/tpc_merge.sv
// ----------------------------------------------------------------------------
// tpc_merge
// Picks the crossing pattern, queues the triangle and emits its vertices.
// ----------------------------------------------------------------------------
module tpc_merge #(
	parameter int FIFO_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  tpc_pkg::vtx_t v0,
	input  tpc_pkg::vtx_t v1,
	input  tpc_pkg::vtx_t v2,
	input  tpc_pkg::vtx_t i01,
	input  tpc_pkg::vtx_t i02,
	input  tpc_pkg::vtx_t i12,
	input  tpc_pkg::edge_flags_t f01,
	input  tpc_pkg::edge_flags_t f02,
	input  tpc_pkg::edge_flags_t f12,
	output logic pop,
	output tpc_pkg::result_t result,
	output logic strobe
);
	import tpc_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	kind_t kind;
	tri_rec_t rec_s1;
	logic rec_vld_s1;
	tri_rec_t mem [FIFO_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] fill_q;
	tri_rec_t cur_q;
	logic cur_vld_q;
	logic [2:0] idx_q;
	logic fin;
	pt_t pt;
	result_t res_next;

	always_comb begin
		if (f01.pos_a && f01.pos_b && f02.pos_b)
			kind = K_CULL;
		else if (f01.crossing == CROSS_B_OUT && f12.crossing == CROSS_A_OUT)
			kind = K_V1_OUT;
		else if (f02.crossing == CROSS_B_OUT && f12.crossing == CROSS_B_OUT)
			kind = K_V2_OUT;
		else if (f01.crossing == CROSS_A_OUT && f02.crossing == CROSS_A_OUT)
			kind = K_V0_OUT;
		else if (f01.crossing == CROSS_A_OUT && f12.crossing == CROSS_B_OUT)
			kind = K_V1_IN;
		else if (f02.crossing == CROSS_A_OUT && f12.crossing == CROSS_A_OUT)
			kind = K_V2_IN;
		else if (f01.crossing == CROSS_B_OUT && f02.crossing == CROSS_B_OUT)
			kind = K_V0_IN;
		else
			kind = K_KEEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_s1 <= 1'b0;
		end else begin
			rec_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rec_s1.kind <= kind;
		rec_s1.pts[PT_V0] <= v0;
		rec_s1.pts[PT_V1] <= v1;
		rec_s1.pts[PT_V2] <= v2;
		rec_s1.pts[PT_I01] <= i01;
		rec_s1.pts[PT_I02] <= i02;
		rec_s1.pts[PT_I12] <= i12;
	end

	assign fin = cur_vld_q && (idx_q == kind_count(cur_q.kind) - 3'd1);
	assign pop = (fill_q != '0) && (!cur_vld_q || fin);

	always_ff @(posedge clk) begin
		if (rec_vld_s1)
			mem[wr_ptr_q] <= rec_s1;
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			cur_vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (rec_vld_s1)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (AW+1)'(rec_vld_s1) - (AW+1)'(pop);
			if (pop)
				cur_vld_q <= 1'b1;
			else if (fin)
				cur_vld_q <= 1'b0;
			if (pop || fin)
				idx_q <= '0;
			else if (cur_vld_q)
				idx_q <= idx_q + 3'd1;
		end
	end

	always_comb begin
		pt = pick_point(cur_q.kind, idx_q);
		res_next.out_x = cur_q.pts[pt].x;
		res_next.out_y = cur_q.pts[pt].y;
		res_next.out_z = cur_q.pts[pt].z;
		res_next.out_w = cur_q.pts[pt].w;
		res_next.end_of_triangle = (idx_q == 3'd2) || (idx_q == 3'd5);
		res_next.last = fin;
		res_next.tri_status = (cur_q.kind == K_KEEP) ? ST_KEPT : ST_CLIP;
		if (cur_q.kind == K_CULL) begin
			res_next.out_x = '0;
			res_next.out_y = '0;
			res_next.out_z = '0;
			res_next.out_w = '0;
			res_next.end_of_triangle = 1'b0;
			res_next.tri_status = ST_CULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cur_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_next;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_vld_s1 && !pop |-> fill_q < (AW+1)'(FIFO_DEPTH))
		else $error("triangle queue overflow");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last && result.tri_status != ST_CULL |-> result.end_of_triangle)
		else $error("last vertex does not close a triangle");
	a_fin_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin && fill_q == '0 && !rec_vld_s1 |=> !cur_vld_q)
		else $error("serializer kept running after last vertex");
`endif

endmodule

>>> hdl/triangle_plane_clipper_core.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips one homogeneous triangle per item against a configured plane.
//
//   channel   signals                          direction
//   config    cfg_we, cfg_index, cfg_data      in
//   triangle  start, busy, tri_in              in (busy out)
//   vertex    strobe, result                   out
//
// An item enters every cycle while busy is low; results show up one vertex per
// cycle, 1 to 6 per item.
// Sustained rate is set by the output port: one vertex per cycle, up to 6
// vertices per item; a queue of FIFO_DEPTH triangles absorbs bursts.
// busy rises when items in flight plus queued reach the queue depth.
// Reset clears the plane registers and all valid/pointer state.
// ----------------------------------------------------------------------------
module triangle_plane_clipper_core #(
	parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  tpc_pkg::reg_idx_t cfg_index,
	input  tpc_pkg::coord_t cfg_data,
	input  logic start,
	output logic busy,
	input  tpc_pkg::tri_in_t tri_in,
	output logic strobe,
	output tpc_pkg::result_t result
);
	import tpc_pkg::*;

	localparam int EDGE_LAT = FRAC_BITS + 3;
	localparam int PIPE_LAT = 2 + EDGE_LAT;
	localparam int FIFO_DEPTH = 1 << $clog2(PIPE_LAT + 3);
	localparam int CNTW = $clog2(FIFO_DEPTH + 1);

	plane_t plane_q;
	vtx_t vin [3];
	vtx_t vs [3];
	score_t fs [3];
	vtx_t a01, b01, p01, a02, b02, p02, a12, b12, p12;
	edge_flags_t f01, f02, f12;
	logic [PIPE_LAT-1:0] vld_q;
	logic [CNTW-1:0] count_q;
	logic accept, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NX: plane_q.nx <= cfg_data;
				REG_NY: plane_q.ny <= cfg_data;
				REG_NZ: plane_q.nz <= cfg_data;
				REG_NW: plane_q.nw <= cfg_data;
				REG_OFFSET: plane_q.offset <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vin[0] = '{tri_in.v0_x, tri_in.v0_y, tri_in.v0_z, tri_in.v0_w};
	assign vin[1] = '{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z, tri_in.v1_w};
	assign vin[2] = '{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z, tri_in.v2_w};

	for (genvar i = 0; i < 3; i++) begin : g_score
		tpc_score_lane #(.FRAC_BITS(FRAC_BITS)) u_score (
			.clk(clk), .plane(plane_q), .v(vin[i]), .v_s2(vs[i]), .f_s2(fs[i])
		);
	end

	tpc_edge_lane #(.FRAC_BITS(FRAC_BITS)) u_e01 (
		.clk(clk), .a(vs[0]), .b(vs[1]), .f_a(fs[0]), .f_b(fs[1]),
		.a_o(a01), .b_o(b01), .p_o(p01), .flags_o(f01)
	);
	tpc_edge_lane #(.FRAC_BITS(FRAC_BITS)) u_e02 (
		.clk(clk), .a(vs[0]), .b(vs[2]), .f_a(fs[0]), .f_b(fs[2]),
		.a_o(a02), .b_o(b02), .p_o(p02), .flags_o(f02)
	);
	tpc_edge_lane #(.FRAC_BITS(FRAC_BITS)) u_e12 (
		.clk(clk), .a(vs[1]), .b(vs[2]), .f_a(fs[1]), .f_b(fs[2]),
		.a_o(a12), .b_o(b12), .p_o(p12), .flags_o(f12)
	);

	assign accept = start && !busy;
	assign busy = count_q >= CNTW'(FIFO_DEPTH);

	// items in the pipe or the queue, not yet taken by the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			count_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
			count_q <= count_q + CNTW'(accept) - CNTW'(pop);
		end
	end

	tpc_merge #(.FIFO_DEPTH(FIFO_DEPTH)) u_merge (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_q[PIPE_LAT-1]),
		.v0(a01), .v1(b01), .v2(b02), .i01(p01), .i02(p02), .i12(p12),
		.f01(f01), .f02(f02), .f12(f12),
		.pop(pop), .result(result), .strobe(strobe)
	);

	// a12 and b12 duplicate vertices already carried by the other edges
	logic unused_dup;
	assign unused_dup = ^{a02, a12, b12};

endmodule
